@@ hw/rtl/cascaded_interrupt_controller_defines.svh @@
// assertion macros for the interrupt controller
`ifndef CASCADED_INTERRUPT_CONTROLLER_DEFINES_SVH
`define CASCADED_INTERRUPT_CONTROLLER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define CIC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cic assertion failed");

// next-cycle implication, disabled while in reset
`define CIC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cic assertion failed");

`endif

@@ hw/rtl/cic_pkg.sv @@
package cic_pkg;

  localparam int LINES  = 8;
  localparam int LINE_W = $clog2(LINES);
  localparam int DATA_W = 8;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_LINE  = 2'd2,
    OP_ACK   = 2'd3
  } op_t;

  localparam logic PORT_CMD    = 1'b0;
  localparam logic PORT_DATA   = 1'b1;
  localparam logic CHIP_MASTER = 1'b0;
  localparam logic CHIP_SLAVE  = 1'b1;

  localparam logic CFG_MASTER_LEVEL = 1'b0;
  localparam logic CFG_SLAVE_LEVEL  = 1'b1;

  localparam int DEFAULT_CASCADE_LINE = 2;

  localparam logic [DATA_W-1:0] MASTER_BASE_RST = 8'h08;
  localparam logic [DATA_W-1:0] SLAVE_BASE_RST  = 8'h70;
  localparam logic [LINE_W-1:0] SPURIOUS_LINE   = LINE_W'(LINES - 1);

  // command word bit positions
  localparam int ICW1_IC4_BIT  = 0;
  localparam int ICW1_SNGL_BIT = 1;
  localparam int ICW4_AEOI_BIT = 1;
  localparam int OCW3_SEL_BIT  = 3;
  localparam int ICW1_SEL_BIT  = 4;
  localparam int OCW2_EOI_BIT  = 5;
  localparam int OCW2_SL_BIT   = 6;

  localparam logic [DATA_W-1:0] OCW3_SEL_MASK = 8'hE7;
  localparam logic [DATA_W-1:0] OCW3_RD_IRR   = 8'h02;
  localparam logic [DATA_W-1:0] OCW3_RD_ISR   = 8'h03;

  localparam logic [2:0] STEP_ICW2 = 3'd1;
  localparam logic [2:0] STEP_ICW3 = 3'd2;
  localparam logic [2:0] STEP_ICW4 = 3'd3;
  localparam logic [2:0] STEP_DONE = 3'd4;
  localparam logic [2:0] STEP_IDLE = 3'd0;

  typedef logic [LINES-1:0] lines_t;

  typedef struct packed {
    logic              wr_cmd;
    logic              wr_data;
    logic [DATA_W-1:0] data;
    logic              line_chg;
    logic [LINE_W-1:0] line_idx;
    logic              line_lvl;
    logic              ack;
    logic              casc_en;
    logic              casc_lvl;
  } cic_ctrl_t;

  typedef struct packed {
    lines_t            irr;
    lines_t            isr;
    lines_t            imr;
    logic              show_isr;
    logic [DATA_W-1:0] base;
    logic              has_req_pre;
    logic [LINE_W-1:0] ack_line;
    logic              has_req_post;
  } cic_stat_t;

  typedef struct packed {
    lines_t levels;
    lines_t irr;
  } line_state_t;

  function automatic logic [LINE_W-1:0] lowest_idx(input lines_t v);
    logic [LINE_W-1:0] idx;
    idx = '0;
    for (int i = LINES - 1; i >= 0; i--) begin
      if (v[i]) idx = LINE_W'(i);
    end
    return idx;
  endfunction

  // pending request beats everything in service below its priority
  function automatic logic has_request(input lines_t irr, input lines_t isr, input lines_t imr);
    lines_t pend;
    lines_t isr_low;
    pend    = irr & ~imr & ~isr;
    isr_low = isr & (~isr + lines_t'(1));
    return |(pend & (isr_low - lines_t'(1)));
  endfunction

  function automatic line_state_t set_line(input line_state_t s, input logic [LINE_W-1:0] idx,
                                           input logic active, input lines_t lvl_mask);
    line_state_t r;
    r = s;
    if (s.levels[idx] != active) begin
      r.levels[idx] = active;
      if (active) r.irr[idx] = 1'b1;
      else if (lvl_mask[idx]) r.irr[idx] = 1'b0;
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/cic_core.sv @@
module cic_core import cic_pkg::*; #(
  parameter logic [DATA_W-1:0] RESET_BASE = MASTER_BASE_RST,
  parameter int                CASC_IDX   = DEFAULT_CASCADE_LINE
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cic_ctrl_t ctrl,
  input  lines_t    lvl_mask,
  output cic_stat_t stat
);

  localparam logic [LINE_W-1:0] CASC = LINE_W'(CASC_IDX);

  lines_t            irr_r, irr_nxt;
  lines_t            isr_r, isr_nxt;
  lines_t            imr_r, imr_nxt;
  lines_t            lev_r, lev_nxt;
  logic [DATA_W-1:0] base_r, base_nxt;
  logic [DATA_W-1:0] icw2_r, icw2_nxt;
  logic [1:0]        icw1_r, icw1_nxt;
  logic              aeoi_r, aeoi_nxt;
  logic [2:0]        step_r, step_nxt;
  logic              show_r, show_nxt;

  lines_t            pend;
  logic              has_pre;
  logic [LINE_W-1:0] take_idx;
  logic [LINE_W-1:0] eoi_idx;
  logic [2:0]        step_inc;
  line_state_t       ls;

  assign pend     = irr_r & ~imr_r & ~isr_r;
  assign has_pre  = has_request(irr_r, isr_r, imr_r);
  assign take_idx = lowest_idx(pend);

  always_comb begin
    irr_nxt  = irr_r;
    isr_nxt  = isr_r;
    imr_nxt  = imr_r;
    lev_nxt  = lev_r;
    base_nxt = base_r;
    icw2_nxt = icw2_r;
    icw1_nxt = icw1_r;
    aeoi_nxt = aeoi_r;
    step_nxt = step_r;
    show_nxt = show_r;
    eoi_idx  = '0;
    step_inc = step_r + 3'd1;
    ls       = '0;

    if (ctrl.wr_cmd) begin
      if (ctrl.data[ICW1_SEL_BIT]) begin
        icw1_nxt = ctrl.data[1:0];
        if (!ctrl.data[ICW1_IC4_BIT]) aeoi_nxt = 1'b0;
        step_nxt = STEP_ICW2;
        imr_nxt  = '0;
        isr_nxt  = '0;
        irr_nxt  = '0;
        show_nxt = 1'b0;
      end else if (!ctrl.data[OCW3_SEL_BIT]) begin
        if (ctrl.data[OCW2_EOI_BIT]) begin
          eoi_idx = ctrl.data[OCW2_SL_BIT] ? ctrl.data[LINE_W-1:0] : lowest_idx(isr_r);
          isr_nxt[eoi_idx] = 1'b0;
        end
      end else begin
        if ((ctrl.data & OCW3_SEL_MASK) == OCW3_RD_IRR) show_nxt = 1'b0;
        else if ((ctrl.data & OCW3_SEL_MASK) == OCW3_RD_ISR) show_nxt = 1'b1;
      end
    end else if (ctrl.wr_data) begin
      if (step_r >= STEP_DONE || step_r == STEP_IDLE) begin
        imr_nxt = ctrl.data;
      end else begin
        if (step_r == STEP_ICW2) icw2_nxt = ctrl.data;
        if (step_r == STEP_ICW4) aeoi_nxt = ctrl.data[ICW4_AEOI_BIT];
        if (icw1_r[ICW1_SNGL_BIT] && step_inc == STEP_ICW3) step_inc = STEP_ICW4;
        if ((!icw1_r[ICW1_IC4_BIT] && step_inc == STEP_ICW4) || step_inc >= STEP_DONE) begin
          step_inc = STEP_DONE;
          base_nxt = icw2_nxt;
        end
        step_nxt = step_inc;
      end
    end else if (ctrl.line_chg) begin
      ls = set_line('{levels: lev_r, irr: irr_r}, ctrl.line_idx, ctrl.line_lvl, lvl_mask);
      lev_nxt = ls.levels;
      irr_nxt = ls.irr;
    end else if (ctrl.ack && has_pre) begin
      if (!aeoi_r) isr_nxt[take_idx] = 1'b1;
      if (!lvl_mask[take_idx]) irr_nxt[take_idx] = 1'b0;
    end

    // cascade input follows the slave output after the operation
    if (ctrl.casc_en) begin
      ls = set_line('{levels: lev_nxt, irr: irr_nxt}, CASC, ctrl.casc_lvl, lvl_mask);
      lev_nxt = ls.levels;
      irr_nxt = ls.irr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      irr_r  <= '0;
      isr_r  <= '0;
      imr_r  <= '0;
      lev_r  <= '0;
      base_r <= RESET_BASE;
      icw2_r <= '0;
      icw1_r <= '0;
      aeoi_r <= 1'b0;
      step_r <= STEP_DONE;
      show_r <= 1'b0;
    end else begin
      irr_r  <= irr_nxt;
      isr_r  <= isr_nxt;
      imr_r  <= imr_nxt;
      lev_r  <= lev_nxt;
      base_r <= base_nxt;
      icw2_r <= icw2_nxt;
      icw1_r <= icw1_nxt;
      aeoi_r <= aeoi_nxt;
      step_r <= step_nxt;
      show_r <= show_nxt;
    end
  end

  assign stat.irr          = irr_r;
  assign stat.isr          = isr_r;
  assign stat.imr          = imr_r;
  assign stat.show_isr     = show_r;
  assign stat.base         = base_r;
  assign stat.has_req_pre  = has_pre;
  assign stat.ack_line     = take_idx;
  assign stat.has_req_post = has_request(irr_nxt, isr_nxt, imr_nxt);

endmodule

@@ hw/rtl/cascaded_interrupt_controller.sv @@
// Cascaded master/slave pair of 8-line interrupt controllers, slave wired to master line
// CASCADE_LINE. One transfer in gives one transfer out: a bus read, a command or data write,
// a line change or an acknowledge, answered with read data, vector and the CPU interrupt
// level after the operation. An item is held in an input register, passes once through both
// controllers' next-state logic, and its result lands in an output register; one item is
// taken every cycle while the output side keeps up. Fixed priority, line 0 highest; level/edge
// selection per line comes from the two configuration registers, which should be written while
// no transfer is pending.
`include "cascaded_interrupt_controller_defines.svh"

module cascaded_interrupt_controller import cic_pkg::*; #(
  parameter int CASCADE_LINE = DEFAULT_CASCADE_LINE
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic        in_chip_select,
  input  logic        in_port_select,
  input  logic [7:0]  in_write_data,
  input  logic [3:0]  in_irq_line,
  input  logic        in_line_level,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_read_data,
  output logic [7:0]  out_vector,
  output logic        out_cpu_interrupt
);

  localparam logic [LINE_W-1:0] CASC = LINE_W'(CASCADE_LINE);

  lines_t            m_lvl_r, s_lvl_r;
  logic              s1_valid_r;
  op_t               s1_op_r;
  logic              s1_cs_r;
  logic              s1_port_r;
  logic [DATA_W-1:0] s1_wd_r;
  logic [3:0]        s1_line_r;
  logic              s1_lvl_r;

  logic              out_valid_r;
  logic [DATA_W-1:0] out_rd_r, out_rd_nxt;
  logic [DATA_W-1:0] out_vec_r, out_vec_nxt;
  logic              out_irq_r;

  logic      adv;
  cic_ctrl_t m_ctrl, s_ctrl;
  cic_stat_t m_stat, s_stat;
  cic_stat_t rd_stat;
  logic      slave_ack;

  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_lvl_r <= '0;
      s_lvl_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_MASTER_LEVEL) m_lvl_r <= cfg_wdata;
      if (cfg_index == CFG_SLAVE_LEVEL) s_lvl_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op_r   <= op_t'(in_operation);
      s1_cs_r   <= in_chip_select;
      s1_port_r <= in_port_select;
      s1_wd_r   <= in_write_data;
      s1_line_r <= in_irq_line;
      s1_lvl_r  <= in_line_level;
    end
  end

  assign slave_ack = adv && s1_op_r == OP_ACK && m_stat.has_req_pre && m_stat.ack_line == CASC;

  always_comb begin
    m_ctrl          = '0;
    m_ctrl.wr_cmd   = adv && s1_op_r == OP_WRITE && s1_port_r == PORT_CMD
                      && s1_cs_r == CHIP_MASTER;
    m_ctrl.wr_data  = adv && s1_op_r == OP_WRITE && s1_port_r == PORT_DATA
                      && s1_cs_r == CHIP_MASTER;
    m_ctrl.data     = s1_wd_r;
    m_ctrl.line_chg = adv && s1_op_r == OP_LINE && s1_line_r[3] == CHIP_MASTER;
    m_ctrl.line_idx = s1_line_r[LINE_W-1:0];
    m_ctrl.line_lvl = s1_lvl_r;
    m_ctrl.ack      = adv && s1_op_r == OP_ACK;
    m_ctrl.casc_en  = adv;
    m_ctrl.casc_lvl = s_stat.has_req_post;

    s_ctrl          = '0;
    s_ctrl.wr_cmd   = adv && s1_op_r == OP_WRITE && s1_port_r == PORT_CMD
                      && s1_cs_r == CHIP_SLAVE;
    s_ctrl.wr_data  = adv && s1_op_r == OP_WRITE && s1_port_r == PORT_DATA
                      && s1_cs_r == CHIP_SLAVE;
    s_ctrl.data     = s1_wd_r;
    s_ctrl.line_chg = adv && s1_op_r == OP_LINE && s1_line_r[3] == CHIP_SLAVE;
    s_ctrl.line_idx = s1_line_r[LINE_W-1:0];
    s_ctrl.line_lvl = s1_lvl_r;
    s_ctrl.ack      = slave_ack;
    s_ctrl.casc_en  = 1'b0;
    s_ctrl.casc_lvl = 1'b0;
  end

  cic_core #(
    .RESET_BASE (MASTER_BASE_RST),
    .CASC_IDX   (CASCADE_LINE)
  ) u_master (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (m_ctrl),
    .lvl_mask (m_lvl_r),
    .stat     (m_stat)
  );

  cic_core #(
    .RESET_BASE (SLAVE_BASE_RST),
    .CASC_IDX   (CASCADE_LINE)
  ) u_slave (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (s_ctrl),
    .lvl_mask (s_lvl_r),
    .stat     (s_stat)
  );

  assign rd_stat = (s1_cs_r == CHIP_SLAVE) ? s_stat : m_stat;

  always_comb begin
    out_rd_nxt  = '0;
    out_vec_nxt = '0;
    case (s1_op_r)
      OP_READ: begin
        if (s1_port_r == PORT_DATA) out_rd_nxt = rd_stat.imr;
        else out_rd_nxt = rd_stat.show_isr ? rd_stat.isr : rd_stat.irr;
      end
      OP_ACK: begin
        if (!m_stat.has_req_pre) begin
          out_vec_nxt = m_stat.base + DATA_W'(SPURIOUS_LINE);
        end else if (m_stat.ack_line != CASC) begin
          out_vec_nxt = m_stat.base + DATA_W'(m_stat.ack_line);
        end else if (!s_stat.has_req_pre) begin
          out_vec_nxt = s_stat.base + DATA_W'(SPURIOUS_LINE);
        end else begin
          out_vec_nxt = s_stat.base + DATA_W'(s_stat.ack_line);
        end
      end
      default: begin
        out_rd_nxt  = '0;
        out_vec_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_rd_r  <= out_rd_nxt;
      out_vec_r <= out_vec_nxt;
      out_irq_r <= m_stat.has_req_post;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_read_data     = out_rd_r;
  assign out_vector        = out_vec_r;
  assign out_cpu_interrupt = out_irq_r;

  // an empty output register never blocks the input side
  `CIC_ASSERT_SAME(a_ready_when_empty, clk, rst_n, !out_valid_r, in_ready)
  // vector only on acknowledge
  `CIC_ASSERT_NEXT(a_vec_only_ack, clk, rst_n, adv && s1_op_r != OP_ACK, out_vector == '0)
  // read data only on bus read
  `CIC_ASSERT_NEXT(a_rd_only_read, clk, rst_n, adv && s1_op_r != OP_READ, out_read_data == '0)
  // slave acknowledged only through the cascade line
  `CIC_ASSERT_SAME(a_slave_ack_casc, clk, rst_n, slave_ack, m_stat.ack_line == CASC && adv)

endmodule
